/* sv/rdq_pkg.sv */
package rdq_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int FILL_W  = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_BACK  = 2'd0,
		CMD_ADD_FRONT = 2'd1,
		CMD_ROT_FWD   = 2'd2,
		CMD_ROT_BACK  = 2'd3
	} cmd_e;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} rsp_status_e;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_e;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // word accepted: latch it and launch the RAM read
		logic exec;     // commit the operation and load the result register
	} dp_cmd_t;

	// (base + off) mod DEPTH, off at most DEPTH
	function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] base,
		logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] ring_inc(logic [PTR_W-1:0] base);
		return (base == PTR_W'(DEPTH - 1)) ? '0 : base + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ring_dec(logic [PTR_W-1:0] base);
		return (base == '0) ? PTR_W'(DEPTH - 1) : base - PTR_W'(1);
	endfunction

endpackage

/* sv/rdq_in_if.sv */
interface rdq_in_if;
	logic                         valid;
	logic                         ready;
	logic [rdq_pkg::CMD_W-1:0]    command;
	logic [rdq_pkg::VALUE_W-1:0]  entry_value;

	modport source (output valid, output command, output entry_value, input ready);
	modport sink   (input valid, input command, input entry_value, output ready);
endinterface

/* sv/rdq_out_if.sv */
interface rdq_out_if;
	logic                         valid;
	logic                         ready;
	logic [rdq_pkg::VALUE_W-1:0]  result_value;
	logic [rdq_pkg::STAT_W-1:0]   status;
	logic [rdq_pkg::FILL_W-1:0]   fill_count;

	modport source (output valid, output result_value, output status, output fill_count,
		input ready);
	modport sink   (input valid, input result_value, input status, input fill_count,
		output ready);
endinterface

/* sv/rdq_ram.sv */
module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/rdq_ctrl.sv */
module rdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rdq_pkg::dp_cmd_t  dp_cmd
);

	rdq_pkg::state_e state_q, state_d;
	logic            out_valid_q, out_valid_d;
	logic            out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		dp_cmd.capture = 1'b0;
		dp_cmd.exec    = 1'b0;
		out_valid_d    = out_valid_q && !out_ready;
		unique case (state_q)
			rdq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.capture = 1'b1;
					state_d        = rdq_pkg::S_EXEC;
				end
			end
			rdq_pkg::S_EXEC: begin
				// hold here until the output register can take the result
				if (out_free) begin
					dp_cmd.exec = 1'b1;
					out_valid_d = 1'b1;
					state_d     = rdq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rdq_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.capture |=> state_q == rdq_pkg::S_EXEC)
		else $error("capture not followed by execute state");

	a_exec_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.exec |=> out_valid_q)
		else $error("executed word did not reach the output register");

endmodule

/* sv/rdq_datapath.sv */
module rdq_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rdq_pkg::dp_cmd_t              dp_cmd,
	input  logic [rdq_pkg::CMD_W-1:0]     command,
	input  logic [rdq_pkg::VALUE_W-1:0]   entry_value,
	output logic [rdq_pkg::VALUE_W-1:0]   result_value,
	output logic [rdq_pkg::STAT_W-1:0]    status,
	output logic [rdq_pkg::FILL_W-1:0]    fill_count
);

	logic [rdq_pkg::PTR_W-1:0]      front_q, front_d;
	logic [rdq_pkg::CNT_W-1:0]      count_q, count_d;
	rdq_pkg::cmd_e                  cmd_q;
	logic [rdq_pkg::DATA_WIDTH-1:0] word_q;
	logic [rdq_pkg::VALUE_W-1:0]    result_value_q;
	rdq_pkg::rsp_status_e           status_q;
	logic [rdq_pkg::FILL_W-1:0]     fill_count_q;

	rdq_pkg::cmd_e                  in_cmd;
	logic [rdq_pkg::PTR_W-1:0]      raddr;
	logic [rdq_pkg::DATA_WIDTH-1:0] rdata;
	logic                           we;
	logic [rdq_pkg::PTR_W-1:0]      waddr;
	logic [rdq_pkg::DATA_WIDTH-1:0] wdata;
	logic [rdq_pkg::VALUE_W-1:0]    value_d;
	rdq_pkg::rsp_status_e           status_d;
	logic                           empty, full;

	assign in_cmd = rdq_pkg::cmd_e'(command);

	// read launched at accept; pointers are settled then
	always_comb begin
		if (in_cmd == rdq_pkg::CMD_ROT_BACK) begin
			raddr = rdq_pkg::ring_add(front_q, count_q - rdq_pkg::CNT_W'(1));
		end else begin
			raddr = front_q;
		end
	end

	rdq_ram #(
		.WIDTH (rdq_pkg::DATA_WIDTH),
		.DEPTH (rdq_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (dp_cmd.capture),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign empty = (count_q == '0);
	assign full  = (count_q == rdq_pkg::CNT_W'(rdq_pkg::DEPTH));

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		we       = 1'b0;
		waddr    = rdq_pkg::ring_add(front_q, count_q);
		wdata    = word_q;
		value_d  = '0;
		status_d = rdq_pkg::STAT_OK;
		unique case (cmd_q)
			rdq_pkg::CMD_ADD_BACK: begin
				if (full) begin
					status_d = rdq_pkg::STAT_FULL;
				end else begin
					we      = dp_cmd.exec;
					count_d = count_q + rdq_pkg::CNT_W'(1);
				end
			end
			rdq_pkg::CMD_ADD_FRONT: begin
				if (full) begin
					status_d = rdq_pkg::STAT_FULL;
				end else begin
					front_d = rdq_pkg::ring_dec(front_q);
					waddr   = front_d;
					we      = dp_cmd.exec;
					count_d = count_q + rdq_pkg::CNT_W'(1);
				end
			end
			rdq_pkg::CMD_ROT_FWD: begin
				if (empty) begin
					status_d = rdq_pkg::STAT_EMPTY;
				end else begin
					// when full, back slot wraps onto the front: rewritten in place
					wdata   = rdata;
					value_d = rdq_pkg::VALUE_W'(rdata);
					we      = dp_cmd.exec;
					front_d = rdq_pkg::ring_inc(front_q);
				end
			end
			rdq_pkg::CMD_ROT_BACK: begin
				if (empty) begin
					status_d = rdq_pkg::STAT_EMPTY;
				end else begin
					front_d = rdq_pkg::ring_dec(front_q);
					waddr   = front_d;
					wdata   = rdata;
					value_d = rdq_pkg::VALUE_W'(rdata);
					we      = dp_cmd.exec;
				end
			end
			default: begin
				status_d = rdq_pkg::STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (dp_cmd.exec) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q  <= in_cmd;
			word_q <= rdq_pkg::DATA_WIDTH'(entry_value);
		end
		if (dp_cmd.exec) begin
			result_value_q <= value_d;
			status_q       <= status_d;
			fill_count_q   <= rdq_pkg::FILL_W'(count_d);
		end
	end

	assign result_value = result_value_q;
	assign status       = status_q;
	assign fill_count   = fill_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rdq_pkg::CNT_W'(rdq_pkg::DEPTH))
		else $error("entry count beyond capacity");

	a_pointers_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!dp_cmd.exec |=> $stable(front_q) && $stable(count_q))
		else $error("pointers moved without an executed word");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.exec && full
		&& (cmd_q == rdq_pkg::CMD_ADD_BACK || cmd_q == rdq_pkg::CMD_ADD_FRONT) |-> !we)
		else $error("push written into a full store");

endmodule

/* sv/rotating_deque_ring_buffer_unit.sv */
// Rotating deque held in a ring buffer of rdq_pkg::DEPTH data words.
// req channel (rdq_in_if, sink): command and entry_value; a word is taken at a
// clock edge with req.valid and req.ready high. Commands: push back, push
// front, rotate forward (front word returned and moved to the back), rotate
// backward (back word returned and moved to the front).
// rsp channel (rdq_out_if, source): one word per request with result_value,
// status (ok, empty on rotate, full on push with the word dropped) and
// fill_count after the operation.
// Timing: accepting a request latches it and launches the store read; the
// execute state then writes the store and loads the response register once
// that register is free, and the unit takes no new request until the
// current one has executed. The single-port-write store and its registered
// read are why each request passes through these two states.
// Reset (arst_n low, asynchronous) empties the deque and clears the response
// valid; store contents are left as they were.
// When rsp.ready stays low the response register holds, and the unit takes
// one more request and parks it, ready for the store write, until the
// response register frees up; req.ready stays low meanwhile.
module rotating_deque_ring_buffer_unit (
	input  logic      clk,
	input  logic      arst_n,
	rdq_in_if.sink    req,
	rdq_out_if.source rsp
);

	rdq_pkg::dp_cmd_t dp_cmd;

	rdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.dp_cmd    (dp_cmd)
	);

	rdq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.command      (req.command),
		.entry_value  (req.entry_value),
		.result_value (rsp.result_value),
		.status       (rsp.status),
		.fill_count   (rsp.fill_count)
	);

endmodule

/* tb/rotating_deque_ring_buffer_unit_tb.sv */
module rotating_deque_ring_buffer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600_000;
	localparam int TOTAL_WORDS = 1850;
	localparam int TAIL_CYCLES = 8;
	localparam int EXP_DEPTH   = 16;

	typedef struct packed {
		logic [rdq_pkg::VALUE_W-1:0] result_value;
		rdq_pkg::rsp_status_e        status;
		logic [rdq_pkg::FILL_W-1:0]  fill_count;
	} deque_rsp_t;

	logic clk;
	logic arst_n;

	rdq_in_if  req_if ();
	rdq_out_if rsp_if ();

	rotating_deque_ring_buffer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// predicted deque contents
	logic [rdq_pkg::DATA_WIDTH-1:0] deque_mem [rdq_pkg::DEPTH];
	logic [rdq_pkg::PTR_W-1:0]      deque_front;
	logic [rdq_pkg::CNT_W-1:0]      deque_count;

	// expected responses in accept order
	deque_rsp_t rsp_expect [EXP_DEPTH];
	logic [$clog2(EXP_DEPTH)-1:0] exp_wr_idx = '0;
	logic [$clog2(EXP_DEPTH)-1:0] exp_rd_idx = '0;
	deque_rsp_t rsp_head;

	int err_count   = 0;
	int cycle_count = 0;
	int words_sent  = 0;
	int src_quiet   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [rdq_pkg::PTR_W-1:0] ring_slot(int base, int off);
		return rdq_pkg::PTR_W'((base + off) % rdq_pkg::DEPTH);
	endfunction

	// applies one command to the predicted deque and returns its response word
	function automatic deque_rsp_t apply_command(rdq_pkg::cmd_e cmd,
		logic [rdq_pkg::VALUE_W-1:0] word);
		deque_rsp_t                     r;
		logic [rdq_pkg::PTR_W-1:0]      slot;
		logic [rdq_pkg::DATA_WIDTH-1:0] held;
		r.result_value = '0;
		r.status       = rdq_pkg::STAT_OK;
		unique case (cmd)
			rdq_pkg::CMD_ADD_BACK, rdq_pkg::CMD_ADD_FRONT: begin
				if (deque_count >= rdq_pkg::CNT_W'(rdq_pkg::DEPTH)) begin
					r.status = rdq_pkg::STAT_FULL;
				end else if (cmd == rdq_pkg::CMD_ADD_BACK) begin
					slot = ring_slot(deque_front, deque_count);
					deque_mem[slot] = word[rdq_pkg::DATA_WIDTH-1:0];
					deque_count++;
				end else begin
					deque_front = ring_slot(deque_front, rdq_pkg::DEPTH - 1);
					deque_mem[deque_front] = word[rdq_pkg::DATA_WIDTH-1:0];
					deque_count++;
				end
			end
			rdq_pkg::CMD_ROT_FWD: begin
				if (deque_count == '0) begin
					r.status = rdq_pkg::STAT_EMPTY;
				end else begin
					held = deque_mem[deque_front];
					// at full this lands on the front slot itself
					deque_mem[ring_slot(deque_front, deque_count)] = held;
					deque_front = ring_slot(deque_front, 1);
					r.result_value = rdq_pkg::VALUE_W'(held);
				end
			end
			default: begin
				if (deque_count == '0) begin
					r.status = rdq_pkg::STAT_EMPTY;
				end else begin
					held = deque_mem[ring_slot(deque_front, deque_count - 1)];
					deque_front = ring_slot(deque_front, rdq_pkg::DEPTH - 1);
					deque_mem[deque_front] = held;
					r.result_value = rdq_pkg::VALUE_W'(held);
				end
			end
		endcase
		r.fill_count = rdq_pkg::FILL_W'(deque_count);
		return r;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones, and quiet stretches
	function automatic int pick_gap();
		int r;
		if (src_quiet > 0) begin
			src_quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			src_quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic send_word(rdq_pkg::cmd_e cmd, logic [rdq_pkg::VALUE_W-1:0] word);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_if.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid       = 1'b1;
		req_if.command     = cmd;
		req_if.entry_value = word;
		do @(posedge clk); while (!req_if.ready);
		rsp_expect[exp_wr_idx] = apply_command(cmd, word);
		exp_wr_idx = exp_wr_idx + 1'b1;
		words_sent++;
	endtask

	task automatic wait_drained();
		while (exp_wr_idx != exp_rd_idx) @(posedge clk);
	endtask

	// response side stalls: ready bursts with gaps, now and then a long open run
	initial begin
		int hi_len;
		int lo_len;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hi_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 8);
			case ($urandom_range(0, 9))
				0, 1, 2: lo_len = 0;
				9:       lo_len = $urandom_range(8, 40);
				default: lo_len = $urandom_range(1, 3);
			endcase
			repeat (hi_len) begin
				@(negedge clk);
				rsp_if.ready = 1'b1;
			end
			repeat (lo_len) begin
				@(negedge clk);
				rsp_if.ready = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (exp_wr_idx == exp_rd_idx) begin
				err_count++;
				if (err_count <= 10) begin
					$display("unexpected response: value=%h status=%0d fill=%0d",
						rsp_if.result_value, rsp_if.status, rsp_if.fill_count);
				end
			end else begin
				rsp_head = rsp_expect[exp_rd_idx];
				exp_rd_idx = exp_rd_idx + 1'b1;
				if (rsp_if.result_value !== rsp_head.result_value
					|| rsp_if.status !== rsp_head.status
					|| rsp_if.fill_count !== rsp_head.fill_count) begin
					err_count++;
					if (err_count <= 10) begin
						$display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
							rsp_head.result_value, rsp_head.status, rsp_head.fill_count,
							rsp_if.result_value, rsp_if.status, rsp_if.fill_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// rotates on an empty deque; entry_value must not matter
	task automatic test_empty_rotate();
		send_word(rdq_pkg::CMD_ROT_FWD, 32'hFFFF_FFFF);
		send_word(rdq_pkg::CMD_ROT_BACK, 32'h0000_0000);
	endtask

	// backward rotate of a lone entry keeps it
	task automatic test_single_entry();
		send_word(rdq_pkg::CMD_ADD_BACK, 32'hFFFF_FFFF);
		send_word(rdq_pkg::CMD_ROT_BACK, 32'h1234_5678);
		send_word(rdq_pkg::CMD_ROT_BACK, 32'h0000_0000);
		send_word(rdq_pkg::CMD_ROT_FWD, 32'hFFFF_FFFF);
	endtask

	// both ends, extreme words, then rotates in both directions
	task automatic test_push_ends();
		send_word(rdq_pkg::CMD_ADD_FRONT, 32'h0000_0000);
		send_word(rdq_pkg::CMD_ADD_BACK, 32'hA5A5_A5A5);
		send_word(rdq_pkg::CMD_ADD_FRONT, 32'h5A5A_5A5A);
		send_word(rdq_pkg::CMD_ADD_BACK, 32'h8000_0000);
		send_word(rdq_pkg::CMD_ADD_FRONT, 32'h0000_0001);
		repeat (3) send_word(rdq_pkg::CMD_ROT_FWD, $urandom());
		repeat (3) send_word(rdq_pkg::CMD_ROT_BACK, $urandom());
	endtask

	// random mix of pushes and rotates until the deque is full, draining once at half full
	task automatic test_fill_random();
		int  r;
		bit  paused;
		paused = 1'b0;
		while (deque_count < rdq_pkg::CNT_W'(rdq_pkg::DEPTH)) begin
			if (!paused && deque_count >= rdq_pkg::CNT_W'(rdq_pkg::DEPTH / 2)) begin
				paused = 1'b1;
				@(negedge clk);
				req_if.valid = 1'b0;
				wait_drained();
			end
			r = $urandom_range(0, 99);
			if (r < 20)      send_word(rdq_pkg::CMD_ADD_BACK, $urandom());
			else if (r < 35) send_word(rdq_pkg::CMD_ADD_FRONT, $urandom());
			else if (r < 70) send_word(rdq_pkg::CMD_ROT_FWD, $urandom());
			else             send_word(rdq_pkg::CMD_ROT_BACK, $urandom());
		end
	endtask

	// full deque: pushes are dropped, rotates rewrite in place
	task automatic test_full_deque();
		int r;
		send_word(rdq_pkg::CMD_ADD_BACK, 32'hFFFF_FFFF);
		send_word(rdq_pkg::CMD_ADD_FRONT, 32'h0000_0000);
		send_word(rdq_pkg::CMD_ROT_FWD, $urandom());
		send_word(rdq_pkg::CMD_ROT_BACK, $urandom());
		while (words_sent < TOTAL_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 12)      send_word(rdq_pkg::CMD_ADD_BACK, $urandom());
			else if (r < 25) send_word(rdq_pkg::CMD_ADD_FRONT, $urandom());
			else if (r < 62) send_word(rdq_pkg::CMD_ROT_FWD, $urandom());
			else             send_word(rdq_pkg::CMD_ROT_BACK, $urandom());
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.command     = rdq_pkg::CMD_ADD_BACK;
		req_if.entry_value = '0;
		deque_front        = '0;
		deque_count        = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_rotate();
		test_single_entry();
		test_push_ends();
		test_fill_random();
		test_full_deque();

		@(negedge clk);
		req_if.valid = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/rdq_pkg.sv
sv/rdq_in_if.sv
sv/rdq_out_if.sv
sv/rdq_ram.sv
sv/rdq_ctrl.sv
sv/rdq_datapath.sv
sv/rotating_deque_ring_buffer_unit.sv
tb/rotating_deque_ring_buffer_unit_tb.sv
